>>> rtl/pal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg: shared definitions of the positional array list
// Sizes, operation codes and the command that is broadcast to the cell row.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int DEPTH      = 64;
  localparam int ELEM_WIDTH = 32;

  localparam int OP_W   = 2;
  localparam int POS_W  = 8;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 7;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Width in which positions, counts and cell indexes are compared.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  // Command seen by every cell in the same cycle.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] at;
    elem_t            val;
  } pal_cmd_t;

endpackage
`default_nettype wire

>>> rtl/pal_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_cell: one list slot
// Holds one element; on insert it takes its lower neighbor or the new value,
// on delete it takes its upper neighbor, otherwise it holds.
// ----------------------------------------------------------------------------
module pal_cell (
  input  wire logic                    clk,
  input  wire pal_pkg::pal_cmd_t       cmd,
  input  wire logic [pal_pkg::CMP_W-1:0] idx,
  input  wire pal_pkg::elem_t          lower,
  input  wire pal_pkg::elem_t          upper,
  output pal_pkg::elem_t               q
);
  import pal_pkg::*;

  elem_t q_r;
  elem_t q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (cmd.ins) begin
      if (idx > cmd.at) begin
        q_nxt = lower;
      end else if (idx == cmd.at) begin
        q_nxt = cmd.val;
      end
    end else if (cmd.del) begin
      if (idx >= cmd.at) begin
        q_nxt = upper;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire

>>> rtl/pal_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_row: the row of list cells
// Chains DEPTH cells to their neighbors and selects the element at a position.
// ----------------------------------------------------------------------------
module pal_row (
  input  wire logic                      clk,
  input  wire pal_pkg::pal_cmd_t         cmd,
  input  wire logic [pal_pkg::IDX_W-1:0] sel,
  output pal_pkg::elem_t                 sel_q
);
  import pal_pkg::*;

  elem_t cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    elem_t lower;
    elem_t upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_q[i+1];
    end

    pal_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .idx   (CMP_W'(i)),
      .lower (lower),
      .upper (upper),
      .q     (cell_q[i])
    );
  end

  assign sel_q = cell_q[sel];

endmodule
`default_nettype wire

>>> rtl/positional_array_list_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_list_unit: fixed-capacity ordered list
// Insert, read and delete at a list position over a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage. A request (in_op, in_pos, in_value) is transferred at a rising edge
// where start is high and busy is low. Busy is tied low, so a new request
// may be transferred every cycle.
//
// The list lives in a row of DEPTH cells. All cells see the same command and
// move at once: on insert every cell above the position takes its lower
// neighbor and the cell at the position takes the new value; on delete every
// cell at or above the position takes its upper neighbor. The removed or read
// element is selected from the row before the move.
//
// The result (out_status, out_data, out_length) is shown with out_valid high
// in the cycle after the transfer, for exactly that cycle.
// Throughput is one request per cycle; busy is never raised.
// The receiver cannot stall; a result not taken in its cycle is gone.
//
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result. Cell contents are not cleared; only slots below the length are ever
// read, and every such slot has been written.
// ----------------------------------------------------------------------------
module positional_array_list_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [pal_pkg::OP_W-1:0]   in_op,
  input  wire logic [pal_pkg::POS_W-1:0]  in_pos,
  input  wire logic [pal_pkg::DATA_W-1:0] in_value,
  output logic                            out_valid,
  output logic                            out_status,
  output logic [pal_pkg::DATA_W-1:0]      out_data,
  output logic [pal_pkg::LEN_W-1:0]       out_length
);
  import pal_pkg::*;

  logic             take;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             full;
  logic             ins_err;
  logic             idx_err;
  logic [CMP_W-1:0] ins_at;
  pal_cmd_t         cmd;
  elem_t            sel_q;

  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic              vld_r,    vld_nxt;
  logic              status_r, status_nxt;
  logic [DATA_W-1:0] data_r,   data_nxt;

  // The block never holds requests off.
  assign busy = 1'b0;
  assign take = start && !busy;

  assign pos_x   = CMP_W'(in_pos);
  assign cnt_x   = CMP_W'(cnt_r);
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign ins_err = (pos_x > CMP_W'(DEPTH)) || full;
  // Read and delete need a position strictly below the length.
  assign idx_err = (pos_x >= cnt_x);
  // An insert past the end appends.
  assign ins_at  = (pos_x > cnt_x) ? cnt_x : pos_x;

  always_comb begin
    cmd        = '0;
    cmd.val    = ELEM_WIDTH'(in_value);
    cmd.at     = pos_x;
    cnt_nxt    = cnt_r;
    vld_nxt    = take;
    status_nxt = 1'b1;
    data_nxt   = '0;
    if (take) begin
      unique case (in_op)
        OP_INSERT: begin
          if (!ins_err) begin
            cmd.ins    = 1'b1;
            cmd.at     = ins_at;
            cnt_nxt    = cnt_r + 1'b1;
            status_nxt = 1'b0;
          end
        end
        OP_READ: begin
          if (!idx_err) begin
            status_nxt = 1'b0;
            data_nxt   = DATA_W'(sel_q);
          end
        end
        OP_DELETE: begin
          if (!idx_err) begin
            cmd.del    = 1'b1;
            cnt_nxt    = cnt_r - 1'b1;
            status_nxt = 1'b0;
            data_nxt   = DATA_W'(sel_q);
          end
        end
        default: begin
          status_nxt = 1'b1;
        end
      endcase
    end
  end

  pal_row u_row (
    .clk   (clk),
    .cmd   (cmd),
    .sel   (IDX_W'(pos_x)),
    .sel_q (sel_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    data_r   <= data_nxt;
  end

  assign out_valid  = vld_r;
  assign out_status = status_r;
  assign out_data   = data_r;
  assign out_length = LEN_W'(cnt_r);

`ifndef SYNTHESIS
  // Every transfer gives a result in the next cycle, and nothing else does.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid)
    else $error("missing result after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> !out_valid)
    else $error("result without transfer");

  // The length never passes capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("length beyond capacity");

  // A successful insert grows the list by exactly one.
  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    take && (in_op == OP_INSERT) && !ins_err |=> cnt_r == CNT_W'($past(cnt_r) + 1'b1))
    else $error("insert did not grow the list");

  // An error result never changes the length.
  a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> cnt_r == $past(cnt_r))
    else $error("length changed on error");
`endif

endmodule
`default_nettype wire

>>> tb/positional_array_list_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_unit_tb: self-checking bench of the positional list
// Walks a table of directed requests covering the list's edges (empty, full,
// out-of-range positions, the unused op code), then runs about 1000 random
// requests in phases with different sender gaps. Every result is compared
// field by field with a typed row's expectation or a cycle-free shadow list.
// ----------------------------------------------------------------------------
module positional_array_list_unit_tb;
  import pal_pkg::*;

  // The fourth op code is not defined by the package; the block must reject it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASES = 4;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  length;
  } list_result_t;

  // One row of the directed table. Rows with rand_pos pick a position from 0
  // to the current length and a random value, repeated reps times. Rows with
  // typed set carry an expected result that is used instead of the shadow's.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    int                reps;
    logic              rand_pos;
    logic              typed;
    list_result_t      want;
  } stim_row_t;

  localparam int DIR_ROWS = 25;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   in_op;
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_value;
  logic              out_valid;
  logic              out_status;
  logic [DATA_W-1:0] out_data;
  logic [LEN_W-1:0]  out_length;

  // Shadow of the list: contents, length and the results still owed.
  elem_t        shadow_cells [DEPTH];
  int           shadow_len;
  list_result_t owed_results [$];

  // The driver hands a typed expectation to the monitor along with the request.
  logic         req_typed;
  list_result_t req_want;

  int           xfer_cnt;
  int           result_cnt;
  int           fail_cnt;
  int           op_cnt [4];
  int           err_cnt;
  int           full_rejects;
  int           empty_hits;

  stim_row_t    dir_rows [DIR_ROWS];

  positional_array_list_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_op      (in_op),
    .in_pos     (in_pos),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_data   (out_data),
    .out_length (out_length)
  );

  always #1 clk = ~clk;

  // Applies one request to the shadow list and returns the result it owes.
  function automatic list_result_t apply_request(logic [OP_W-1:0] op,
                                                 logic [POS_W-1:0] pos,
                                                 logic [DATA_W-1:0] value);
    list_result_t res;
    int           at;
    int           i;
    res = '{status: 1'b1, data: '0, length: '0};
    at = int'(pos);
    case (op)
      OP_INSERT: begin
        // Positions past the length but within capacity append at the end.
        if (at <= DEPTH && shadow_len < DEPTH) begin
          if (at > shadow_len) at = shadow_len;
          for (i = shadow_len; i > at; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[at] = elem_t'(value);
          shadow_len++;
          res.status = 1'b0;
        end
      end
      OP_READ: begin
        if (at < shadow_len) begin
          res.status = 1'b0;
          res.data = DATA_W'(shadow_cells[at]);
        end
      end
      OP_DELETE: begin
        if (at < shadow_len) begin
          res.status = 1'b0;
          res.data = DATA_W'(shadow_cells[at]);
          for (i = at + 1; i < shadow_len; i++) shadow_cells[i-1] = shadow_cells[i];
          shadow_len--;
        end
      end
      default: ;
    endcase
    res.length = LEN_W'(shadow_len);
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // Monitor. Results are checked before the request of the same edge is
  // predicted, so the oldest owed result always belongs to an earlier transfer.
  // Everything is sampled at the rising edge, before the block's registers move.
  always @(posedge clk) begin : monitor
    list_result_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        result_cnt++;
        if (owed_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none actual %h/%h/%h",
                   $time, out_status, out_data, out_length);
          fail_cnt++;
        end else begin
          want = owed_results.pop_front();
          compare_field("status", DATA_W'(want.status), DATA_W'(out_status));
          compare_field("data", want.data, out_data);
          compare_field("length", DATA_W'(want.length), DATA_W'(out_length));
        end
      end else if (out_valid !== 1'b0) begin
        $display("%0t ns: out_valid mismatch, expected 0 actual %b", $time, out_valid);
        fail_cnt++;
      end
      if (start && !busy) begin
        if (in_op == OP_INSERT && shadow_len == DEPTH) full_rejects++;
        want = apply_request(in_op, in_pos, in_value);
        if (req_typed) want = req_want;
        owed_results.push_back(want);
        op_cnt[in_op]++;
        if (want.status) err_cnt++;
        if (in_op == OP_DELETE && !want.status && shadow_len == 0) empty_hits++;
        xfer_cnt++;
      end
    end
  end

  // Drives one request at a falling edge and holds it until the monitor has
  // seen the transfer. start stays high on return, so back-to-back requests
  // need no gap; the caller lowers it when the sender goes idle.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] value, input logic typed,
                              input list_result_t want);
    int sent;
    start = 1'b1;
    in_op = op;
    in_pos = pos;
    in_value = value;
    req_typed = typed;
    req_want = want;
    sent = xfer_cnt;
    do @(negedge clk); while (xfer_cnt == sent);
  endtask

  task automatic idle_sender(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Random request. While growing, inserts dominate so the list regularly
  // fills up; while shrinking, deletes dominate so it regularly empties.
  // Most positions fall inside the list, some at its last slot, some at or
  // just past capacity, and a few anywhere in the 8-bit range.
  task automatic send_random(input logic growing);
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    int                pick;
    pick = $urandom_range(99);
    if (growing)
      op = (pick < 60) ? OP_INSERT : (pick < 78) ? OP_READ : (pick < 97) ? OP_DELETE
                                                                         : OP_UNUSED;
    else
      op = (pick < 25) ? OP_INSERT : (pick < 45) ? OP_READ : (pick < 97) ? OP_DELETE
                                                                         : OP_UNUSED;
    pick = $urandom_range(9);
    if (pick < 7) pos = POS_W'($urandom_range(shadow_len));
    else if (pick == 7) pos = POS_W'((shadow_len == 0) ? 0 : shadow_len - 1);
    else if (pick == 8) pos = POS_W'($urandom_range(DEPTH + 1, DEPTH));
    else pos = POS_W'($urandom_range(255));
    pick = $urandom_range(15);
    value = (pick == 0) ? '0 : (pick == 1) ? '1 : DATA_W'($urandom);
    send_request(op, pos, value, 1'b0, '0);
  endtask

  // Pauses the sender until every owed result has come back.
  task automatic drain_results();
    start = 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int           row;
    int           rep;
    int           phase;
    int           item;
    int           window;
    int           gap_pct;
    int           guard;
    logic         growing;
    stim_row_t    r;

    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_INSERT;
    in_pos = '0;
    in_value = '0;
    req_typed = 1'b0;
    req_want = '0;
    shadow_len = 0;
    xfer_cnt = 0;
    result_cnt = 0;
    fail_cnt = 0;
    err_cnt = 0;
    full_rejects = 0;
    empty_hits = 0;
    op_cnt = '{default: 0};

    // Directed table: op, pos, value, reps, random position, typed, expectation.
    dir_rows = '{
      // Read, delete and the unused code on an empty list are rejected.
      '{OP_READ,   8'd0,   32'h0,        1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd0}},
      '{OP_DELETE, 8'd0,   32'h0,        1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd0}},
      '{OP_UNUSED, 8'd0,   32'h0,        1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd0}},
      // Positions beyond capacity are rejected; capacity itself appends.
      '{OP_INSERT, 8'd255, 32'hFFFFFFFF, 1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd0}},
      '{OP_INSERT, 8'd65,  32'h00001234, 1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd0}},
      '{OP_INSERT, 8'd64,  32'hFFFFFFFF, 1,  1'b0, 1'b1, '{1'b0, 32'h0,        7'd1}},
      '{OP_READ,   8'd0,   32'h0,        1,  1'b0, 1'b1, '{1'b0, 32'hFFFFFFFF, 7'd1}},
      '{OP_INSERT, 8'd0,   32'h0,        1,  1'b0, 1'b1, '{1'b0, 32'h0,        7'd2}},
      '{OP_INSERT, 8'd200, 32'h00000005, 1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd2}},
      // A position past the length lands at the end.
      '{OP_INSERT, 8'd5,   32'hA5A5A5A5, 1,  1'b0, 1'b0, '0},
      '{OP_READ,   8'd2,   32'h0,        1,  1'b0, 1'b0, '0},
      '{OP_READ,   8'd3,   32'h0,        1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd3}},
      '{OP_UNUSED, 8'd255, 32'hFFFFFFFF, 1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd3}},
      '{OP_DELETE, 8'd1,   32'h0,        1,  1'b0, 1'b0, '0},
      '{OP_DELETE, 8'd255, 32'h0,        1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd2}},
      // Fill to capacity at random places, then knock on the full list.
      '{OP_INSERT, 8'd0,   32'h0,        62, 1'b1, 1'b0, '0},
      '{OP_INSERT, 8'd0,   32'h5A5A5A5A, 1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd64}},
      '{OP_INSERT, 8'd64,  32'h5A5A5A5A, 1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd64}},
      '{OP_READ,   8'd63,  32'h0,        1,  1'b0, 1'b0, '0},
      '{OP_READ,   8'd64,  32'h0,        1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd64}},
      '{OP_READ,   8'd0,   32'h0,        1,  1'b0, 1'b0, '0},
      // Empty it again from the top and from the bottom.
      '{OP_DELETE, 8'd63,  32'h0,        1,  1'b0, 1'b0, '0},
      '{OP_DELETE, 8'd0,   32'h0,        63, 1'b0, 1'b0, '0},
      '{OP_READ,   8'd0,   32'h0,        1,  1'b0, 1'b1, '{1'b1, 32'h0,        7'd0}},
      '{OP_INSERT, 8'd1,   32'h80000000, 1,  1'b0, 1'b0, '0}
    };

    // Synchronous reset at the start; inputs move only on falling edges.
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    for (row = 0; row < DIR_ROWS; row++) begin
      r = dir_rows[row];
      for (rep = 0; rep < r.reps; rep++) begin
        if (r.rand_pos)
          send_request(r.op, POS_W'($urandom_range(shadow_len)), DATA_W'($urandom),
                       1'b0, '0);
        else
          send_request(r.op, r.pos, r.value, r.typed, r.want);
      end
    end
    drain_results();

    // Random part. Phases differ in how often the sender leaves gaps: none,
    // most of the time, rarely, then none again. Between phases the sender
    // waits until the list has answered every request.
    growing = 1'b1;
    window = $urandom_range(200, 80);
    for (phase = 0; phase < PHASES; phase++) begin
      gap_pct = (phase == 1) ? 73 : (phase == 2) ? 12 : 0;
      for (item = 0; item < RANDOM_ITEMS / PHASES; item++) begin
        if ($urandom_range(99) < gap_pct) idle_sender($urandom_range(5, 1));
        send_random(growing);
        if (--window == 0) begin
          growing = !growing;
          window = $urandom_range(200, 80);
        end
      end
      drain_results();
    end

    // Let the last result settle, with a bound on the wait for stragglers.
    start = 1'b0;
    guard = 0;
    while (owed_results.size() != 0 && guard < 200) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
    if (owed_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, owed_results.size());
      fail_cnt++;
    end

    $display("Covered %0d transfers: %0d inserts, %0d reads, %0d deletes, %0d unused codes.",
             xfer_cnt, op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3]);
    $display("Checked %0d results, %0d errors, %0d full-list inserts, %0d emptying deletes.",
             result_cnt, err_cnt, full_rejects, empty_hits);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: stops a run that hangs and reports it as failed.
  initial begin : watchdog
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/pal_row.sv
rtl/positional_array_list_unit.sv
tb/positional_array_list_unit_tb.sv
